>>> rtl/psu_pkg.sv
// Package: shared types, constants and the Paeth predictor for the scanline unfilter.
`default_nettype none
package psu_pkg;

    // Size defaults
    localparam int DEF_MAX_ROW_BYTES   = 16384;
    localparam int DEF_MAX_PIXEL_BYTES = 8;
    localparam int QUEUE_DEPTH         = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 2'd2;

    // Register widths and reset values
    localparam int PIX_W  = 4;
    localparam int ROWB_W = 15;
    localparam int ROWS_W = 16;
    localparam logic [PIX_W-1:0]  RST_PIXEL_BYTES = 4'd4;
    localparam logic [ROWB_W-1:0] RST_ROW_BYTES   = 15'd16384;
    localparam logic [ROWS_W-1:0] RST_IMAGE_ROWS  = 16'd1;

    // Highest legal filter type byte
    localparam logic [7:0] MAX_FILTER_CODE = 8'd4;

    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4,
        FLT_BAD   = 3'd5
    } t_filter;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       image_start;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       row_end;
        logic       image_end;
        logic       bad_filter;
    } t_out;

    // Classified data byte handed from front to back
    typedef struct packed {
        logic [7:0] in_byte;
        t_filter    filter;
        logic       has_left;
        logic       has_above;
        logic       row_end;
        logic       image_end;
    } t_qctl;

    // Paeth predictor, ties go to left, then above, then upper left
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] p;
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
        da = p - $signed({2'b00, a});
        db = p - $signed({2'b00, b});
        dc = p - $signed({2'b00, c});
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc) begin
            return a;
        end else if (db <= dc) begin
            return b;
        end else begin
            return c;
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/psu_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/psu_fifo.sv
// Short queue between the classifying front and the reconstructing back.
`default_nettype none
module psu_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : AW'(r_wptr + 1'b1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : AW'(r_rptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (!i_push && i_pop) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/psu_front.sv
// Front: accepts stream bytes, latches filter types, tags data bytes with position.
`default_nettype none
module psu_front #(
    parameter int MAX_ROW_BYTES = 16384,
    parameter int XW            = 14
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire psu_pkg::t_in                i_in,
    input  wire logic [psu_pkg::PIX_W-1:0]   i_pix,
    input  wire logic [psu_pkg::ROWB_W-1:0]  i_row_bytes,
    input  wire logic [psu_pkg::ROWS_W-1:0]  i_image_rows,
    output logic                             o_push,
    output logic      [XW-1:0]               o_x,
    output psu_pkg::t_qctl                   o_ctl
);
    import psu_pkg::*;

    localparam int CMPW = (XW + 1 > ROWB_W) ? XW + 1 : ROWB_W;

    logic              r_in_row;
    logic [XW-1:0]     r_x;
    logic [ROWS_W-1:0] r_row_count;
    t_filter           r_filter;

    logic              eff_in_row;
    logic [ROWS_W-1:0] eff_row;
    logic [CMPW-1:0]   rb_c;
    logic [ROWS_W-1:0] rows_c;
    logic              last_col;
    logic              last_row;

    // Clamp row geometry
    always_comb begin
        rb_c = CMPW'(i_row_bytes);
        if (rb_c == '0) begin
            rb_c = CMPW'(1);
        end else if (rb_c > CMPW'(MAX_ROW_BYTES)) begin
            rb_c = CMPW'(MAX_ROW_BYTES);
        end
        rows_c = (i_image_rows == '0) ? ROWS_W'(1) : i_image_rows;
    end

    // Classify the byte and build the queue entry
    always_comb begin
        eff_in_row = i_in.image_start ? 1'b0 : r_in_row;
        eff_row    = i_in.image_start ? '0 : r_row_count;
        last_col   = (CMPW'(r_x) + CMPW'(1)) >= rb_c;
        last_row   = ({1'b0, eff_row} + (ROWS_W + 1)'(1)) >= {1'b0, rows_c};

        o_push          = i_accept && eff_in_row;
        o_x             = r_x;
        o_ctl.in_byte   = i_in.in_byte;
        o_ctl.filter    = r_filter;
        o_ctl.has_left  = CMPW'(r_x) >= CMPW'(i_pix);
        o_ctl.has_above = (eff_row != '0);
        o_ctl.row_end   = last_col;
        o_ctl.image_end = last_col && last_row;
    end

    // Track row, column and filter type
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row    <= 1'b0;
            r_x         <= '0;
            r_row_count <= '0;
            r_filter    <= FLT_NONE;
        end else if (i_accept) begin
            if (!eff_in_row) begin
                r_filter    <= (i_in.in_byte <= MAX_FILTER_CODE) ?
                               t_filter'(i_in.in_byte[2:0]) : FLT_BAD;
                r_in_row    <= 1'b1;
                r_x         <= '0;
                r_row_count <= eff_row;
            end else if (last_col) begin
                r_in_row    <= 1'b0;
                r_row_count <= last_row ? '0 : ROWS_W'(eff_row + 1'b1);
            end else begin
                r_x <= XW'(r_x + 1'b1);
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/psu_back.sv
// Back: reads the prior row, reconstructs each byte and registers the result.
`default_nettype none
module psu_back #(
    parameter int MAX_ROW_BYTES   = 16384,
    parameter int MAX_PIXEL_BYTES = 8,
    parameter int XW              = 14,
    parameter int PBW             = 3
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_head_valid,
    input  wire logic [XW-1:0]  i_head_x,
    input  wire psu_pkg::t_qctl i_head_ctl,
    output logic                o_pop,
    input  wire logic [PBW-1:0] i_pix_idx,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output psu_pkg::t_out       o_out_data
);
    import psu_pkg::*;

    logic           r_b_valid;
    logic [XW-1:0]  r_b_x;
    t_qctl          r_b_ctl;
    logic           r_fwd;
    logic [7:0]     r_fwd_byte;
    logic [7:0]     r_left [MAX_PIXEL_BYTES];
    logic [7:0]     r_upl  [MAX_PIXEL_BYTES];
    logic           r_out_valid;
    t_out           r_out;

    logic           b_adv;
    logic [7:0]     ram_q;
    logic [7:0]     a_val;
    logic [7:0]     b_val;
    logic [7:0]     c_val;
    logic [8:0]     sum_ab;
    logic [7:0]     pred;
    logic           bad;
    logic [7:0]     raw;

    assign b_adv       = r_b_valid && (!r_out_valid || i_out_ready);
    assign o_pop       = i_head_valid && (!r_b_valid || b_adv);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Prior-row line buffer: read ahead for the head entry, write back the result
    psu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_prior (
        .i_clk   (i_clk),
        .i_we    (b_adv),
        .i_waddr (r_b_x),
        .i_wdata (raw),
        .i_re    (o_pop),
        .i_raddr (i_head_x),
        .o_rdata (ram_q)
    );

    // Reconstruct the byte
    always_comb begin
        a_val  = r_b_ctl.has_left ? r_left[i_pix_idx] : 8'd0;
        c_val  = r_b_ctl.has_left ? r_upl[i_pix_idx] : 8'd0;
        b_val  = r_b_ctl.has_above ? (r_fwd ? r_fwd_byte : ram_q) : 8'd0;
        sum_ab = {1'b0, a_val} + {1'b0, b_val};
        bad    = 1'b0;
        case (r_b_ctl.filter)
            FLT_NONE:  pred = 8'd0;
            FLT_SUB:   pred = a_val;
            FLT_UP:    pred = b_val;
            FLT_AVG:   pred = sum_ab[8:1];
            FLT_PAETH: pred = paeth(a_val, b_val, c_val);
            default: begin
                pred = 8'd0;
                bad  = 1'b1;
            end
        endcase
        raw = bad ? 8'd0 : 8'(r_b_ctl.in_byte + pred);
    end

    // Load the working stage, noting a same-address write in flight
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_x      <= i_head_x;
            r_b_ctl    <= i_head_ctl;
            r_fwd      <= b_adv && (r_b_x == i_head_x);
            r_fwd_byte <= raw;
        end
    end

    // Shift left and upper-left history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                r_left[k] <= 8'd0;
                r_upl[k]  <= 8'd0;
            end
        end else if (b_adv) begin
            for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
                r_left[k] <= r_left[k-1];
                r_upl[k]  <= r_upl[k-1];
            end
            r_left[0] <= raw;
            r_upl[0]  <= b_val;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_out.out_byte   <= raw;
            r_out.row_end    <= r_b_ctl.row_end;
            r_out.image_end  <= r_b_ctl.image_end;
            r_out.bad_filter <= bad;
        end
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/png_scanline_unfilter_top.sv
// PNG scanline unfilter: None/Sub/Up/Average/Paeth, one data byte per cycle when not stalled.
// Throughput: one stream byte per cycle while the queue is not full; filter-type bytes give no result.
// A data byte passes through the queue and the working stage into the result register.
// The rate is set by the back stage, which folds in the left neighbor as each byte advances.
// Reset (synchronous, active low) clears control, history and registers to defaults;
// the prior-row RAM is not cleared, since row zero predicts above from zero.
`default_nettype none
module png_scanline_unfilter_top #(
    parameter int MAX_ROW_BYTES   = psu_pkg::DEF_MAX_ROW_BYTES,
    parameter int MAX_PIXEL_BYTES = psu_pkg::DEF_MAX_PIXEL_BYTES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire psu_pkg::t_in                  i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output psu_pkg::t_out                      o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [psu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [psu_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import psu_pkg::*;

    localparam int XW  = $clog2(MAX_ROW_BYTES);
    localparam int PBW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int QW  = XW + $bits(t_qctl);

    logic [PIX_W-1:0]  r_pixel_bytes;
    logic [ROWB_W-1:0] r_row_bytes;
    logic [ROWS_W-1:0] r_image_rows;

    logic [PIX_W-1:0]  pix_c;
    logic [PBW-1:0]    pix_idx;
    logic              in_accept;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    logic [XW-1:0]     f_x;
    t_qctl             f_ctl;
    logic [QW-1:0]     q_head;
    logic [XW-1:0]     head_x;
    t_qctl             head_ctl;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_bytes <= RST_PIXEL_BYTES;
            r_row_bytes   <= RST_ROW_BYTES;
            r_image_rows  <= RST_IMAGE_ROWS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PIXEL_BYTES: r_pixel_bytes <= i_cfg_data[PIX_W-1:0];
                CFG_ROW_BYTES:   r_row_bytes   <= i_cfg_data[ROWB_W-1:0];
                CFG_IMAGE_ROWS:  r_image_rows  <= i_cfg_data[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the pixel stride
    always_comb begin
        pix_c = r_pixel_bytes;
        if (pix_c == '0) begin
            pix_c = PIX_W'(1);
        end else if (pix_c > PIX_W'(MAX_PIXEL_BYTES)) begin
            pix_c = PIX_W'(MAX_PIXEL_BYTES);
        end
        pix_idx = PBW'(pix_c - 1'b1);
    end

    assign o_in_ready = !q_full;
    assign in_accept  = i_in_valid && o_in_ready;

    psu_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .XW            (XW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_in         (i_in_data),
        .i_pix        (pix_c),
        .i_row_bytes  (r_row_bytes),
        .i_image_rows (r_image_rows),
        .o_push       (q_push),
        .o_x          (f_x),
        .o_ctl        (f_ctl)
    );

    psu_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_x, f_ctl}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_head)
    );

    assign head_x   = q_head[QW-1 -: XW];
    assign head_ctl = t_qctl'(q_head[$bits(t_qctl)-1:0]);

    psu_back #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .XW              (XW),
        .PBW             (PBW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!q_empty),
        .i_head_x     (head_x),
        .i_head_ctl   (head_ctl),
        .o_pop        (q_pop),
        .i_pix_idx    (pix_idx),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule
`default_nettype wire

>>> bench/png_scanline_unfilter_checker.sv
`timescale 1ns / 100ps
// Checker for the scanline unfilter: predicts reconstructed bytes and compares each result.
module png_scanline_unfilter_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  psu_pkg::t_in                   i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  psu_pkg::t_out                  i_out_data,
    input  logic                           i_cfg_we,
    input  logic [psu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import psu_pkg::*;

    localparam int ROW_LIMIT = DEF_MAX_ROW_BYTES;
    localparam int PIX_LIMIT = DEF_MAX_PIXEL_BYTES;

    // Predicted decoder state
    bit [7:0]        above_row [ROW_LIMIT];
    bit [7:0]        left_hist [PIX_LIMIT];
    bit [7:0]        upleft_hist [PIX_LIMIT];
    bit [14:0]       col_pos;
    bit [15:0]       row_idx;
    t_filter         cur_filter;

    // Register copies
    bit [PIX_W-1:0]  pix_bytes;
    bit [ROWB_W-1:0] row_len;
    bit [ROWS_W-1:0] image_rows;

    t_out            expected_out [$];
    int              errors;

    // Pick whichever of left, above and upper left lies nearest to left + above - upper left
    function automatic int paeth_choice(input int left, input int up, input int diag);
        int est;
        int dist_l;
        int dist_u;
        int dist_d;
        est    = left + up - diag;
        dist_l = (est > left) ? est - left : left - est;
        dist_u = (est > up) ? est - up : up - est;
        dist_d = (est > diag) ? est - diag : diag - est;
        if (dist_l <= dist_u && dist_l <= dist_d) begin
            return left;
        end
        if (dist_u <= dist_d) begin
            return up;
        end
        return diag;
    endfunction

    // Advance the predicted state by one stream byte; return 1 when a result is due
    function automatic bit reconstruct_byte(input t_in item, output t_out res);
        int unsigned eff_pix;
        int unsigned eff_len;
        int unsigned eff_rows;
        int unsigned x;
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int unsigned pred;
        int          k;
        bit [7:0]    raw;
        bit          bad;
        bit          last_col;
        bit          last_row;
        res = '0;
        if (item.image_start) begin
            row_idx = '0;
            col_pos = '0;
        end

        // Latch the filter type and clear the neighbor history
        if (col_pos == 0) begin
            cur_filter = (item.in_byte <= MAX_FILTER_CODE) ? t_filter'(item.in_byte[2:0])
                                                            : FLT_BAD;
            for (k = 0; k < PIX_LIMIT; k++) begin
                left_hist[k]   = '0;
                upleft_hist[k] = '0;
            end
            col_pos = 15'd1;
            return 1'b0;
        end

        // Clamp registers to their legal ranges
        eff_pix  = (pix_bytes == 0) ? 1 : ((pix_bytes > PIX_LIMIT) ? PIX_LIMIT : pix_bytes);
        eff_len  = (row_len == 0) ? 1 : ((row_len > ROW_LIMIT) ? ROW_LIMIT : row_len);
        eff_rows = (image_rows == 0) ? 1 : image_rows;

        // Gather neighbors; left of the first pixel and above row zero count as zero
        x = col_pos - 1;
        a = (x >= eff_pix) ? left_hist[eff_pix-1] : 0;
        b = (row_idx != 0) ? above_row[x] : 0;
        c = (x >= eff_pix) ? upleft_hist[eff_pix-1] : 0;

        bad = 1'b0;
        case (cur_filter)
            FLT_NONE:  pred = 0;
            FLT_SUB:   pred = a;
            FLT_UP:    pred = b;
            FLT_AVG:   pred = (a + b) >> 1;
            FLT_PAETH: pred = paeth_choice(a, b, c);
            default: begin
                pred = 0;
                bad  = 1'b1;
            end
        endcase
        raw = bad ? 8'h00 : 8'(item.in_byte + pred);

        // Shift history and store the byte for the next row
        for (k = PIX_LIMIT - 1; k > 0; k--) begin
            left_hist[k]   = left_hist[k-1];
            upleft_hist[k] = upleft_hist[k-1];
        end
        left_hist[0]   = raw;
        upleft_hist[0] = 8'(b);
        above_row[x]   = raw;

        // Advance column and row
        last_col = (x + 1 >= eff_len);
        last_row = (row_idx + 1 >= eff_rows);
        if (last_col) begin
            col_pos = '0;
            row_idx = last_row ? 16'd0 : row_idx + 16'd1;
        end else begin
            col_pos = 15'(x + 2);
        end

        res.out_byte   = raw;
        res.row_end    = last_col;
        res.image_end  = last_col && last_row;
        res.bad_filter = bad;
        return 1'b1;
    endfunction

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            errors++;
        end
    endtask

    // Track registers and both channels; check results before predicting new input
    always @(posedge i_clk) begin : watch
        t_out want;
        t_out guess;
        if (!i_rst_n) begin
            pix_bytes  = RST_PIXEL_BYTES;
            row_len    = RST_ROW_BYTES;
            image_rows = RST_IMAGE_ROWS;
            col_pos    = '0;
            row_idx    = '0;
            cur_filter = FLT_NONE;
            expected_out.delete();
            errors     = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PIXEL_BYTES: pix_bytes  = i_cfg_data[PIX_W-1:0];
                    CFG_ROW_BYTES:   row_len    = i_cfg_data[ROWB_W-1:0];
                    CFG_IMAGE_ROWS:  image_rows = i_cfg_data[ROWS_W-1:0];
                    default: ;
                endcase
            end

            // Compare a result transaction with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (expected_out.size() == 0) begin
                    $display("%0t: result %h arrived with none expected, expected nothing",
                             $time, i_out_data);
                    errors++;
                end else begin
                    want = expected_out.pop_front();
                    check_field("out_byte", want.out_byte, i_out_data.out_byte);
                    check_field("row_end", 8'(want.row_end), 8'(i_out_data.row_end));
                    check_field("image_end", 8'(want.image_end), 8'(i_out_data.image_end));
                    check_field("bad_filter", 8'(want.bad_filter),
                                8'(i_out_data.bad_filter));
                end
            end

            // Predict from an input transaction
            if (i_in_valid && i_in_ready) begin
                if (reconstruct_byte(i_in_data, guess)) begin
                    expected_out.push_back(guess);
                end
            end
        end
        o_fail_count <= errors;
        o_pending    <= expected_out.size();
    end

endmodule

>>> bench/tb_png_scanline_unfilter_top.sv
`timescale 1ns / 100ps
// Testbench top: drives the byte stream and registers of the scanline unfilter, gives the verdict.
module tb_png_scanline_unfilter_top;
    import psu_pkg::*;

    localparam int TARGET_ITEMS   = 1000;
    localparam int LONG_ROW_BYTES = 64;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_GAP        = 8;
    localparam int MAX_ROWS_SENT  = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
    localparam logic [7:0]           UNKNOWN_CODE = 8'hFF;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in                   in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out                  out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    bytes_sent;
    int                    results_taken;
    bit                    steady_feed;
    bit                    steady_drain;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    png_scanline_unfilter_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    png_scanline_unfilter_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one byte and hold it until the block takes the transaction
    task automatic send_byte(input logic [7:0] value, input logic start);
        int  gap;
        t_in item;
        gap = steady_feed ? 0 : $urandom_range(0, MAX_GAP);
        item.in_byte     = value;
        item.image_start = start;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // Drop valid and let the pipeline empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_registers(input logic [CFG_DATA_W-1:0] pix_word,
                                   input logic [CFG_DATA_W-1:0] len_word,
                                   input logic [CFG_DATA_W-1:0] rows_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PIXEL_BYTES;
        cfg_data  <= pix_word;
        @(posedge clk);
        cfg_index <= CFG_ROW_BYTES;
        cfg_data  <= len_word;
        @(posedge clk);
        cfg_index <= CFG_IMAGE_ROWS;
        cfg_data  <= rows_word;
        @(posedge clk);
        // The spare index must leave every register alone
        cfg_index <= CFG_SPARE;
        cfg_data  <= 16'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stream one image of random rows; cut_odds n gives a one-in-n chance of cutting it short
    task automatic send_image(input bit with_start, input int unsigned len,
                              input int unsigned rows, input int unsigned cut_odds,
                              output bit cut);
        int unsigned row_cap;
        int unsigned total;
        int unsigned stop;
        int unsigned pos;
        int unsigned data_top;
        logic [7:0]  code;
        row_cap  = (rows > MAX_ROWS_SENT) ? MAX_ROWS_SENT : rows;
        total    = row_cap * (len + 1);
        cut      = (rows > row_cap);
        stop     = total;
        if (cut_odds != 0 && $urandom_range(1, cut_odds) == 1) begin
            cut  = 1'b1;
            stop = $urandom_range(1, total - 1);
        end
        // Small data values make Paeth ties frequent
        data_top = $urandom_range(0, 1) ? 255 : 3;
        for (pos = 0; pos < stop; pos++) begin
            if (pos % (len + 1) == 0) begin
                code = ($urandom_range(0, 11) < 10) ? 8'($urandom_range(0, 4))
                                                     : 8'($urandom_range(5, 255));
                send_byte(code, with_start && pos == 0);
            end else begin
                send_byte(8'($urandom_range(0, data_top)), 1'b0);
            end
        end
    endtask

    // Pick registers, stream a few images, then drain
    task automatic random_phase();
        logic [CFG_DATA_W-1:0] pix_word;
        logic [CFG_DATA_W-1:0] len_word;
        logic [CFG_DATA_W-1:0] rows_word;
        int unsigned           eff_len;
        int unsigned           eff_rows;
        int unsigned           images;
        bit                    with_start;
        bit                    cut;
        // Upper data bits ride along; each register keeps only its own width
        pix_word = 16'($urandom);
        case ($urandom_range(0, 5))
            0:       pix_word[PIX_W-1:0] = '0;
            1:       pix_word[PIX_W-1:0] = '1;
            default: pix_word[PIX_W-1:0] = PIX_W'($urandom_range(1, DEF_MAX_PIXEL_BYTES));
        endcase
        len_word = 16'($urandom);
        case ($urandom_range(0, 7))
            0:       len_word[ROWB_W-1:0] = '0;
            1:       len_word[ROWB_W-1:0] = 15'd1;
            default: len_word[ROWB_W-1:0] = 15'($urandom_range(2, 24));
        endcase
        case ($urandom_range(0, 7))
            0:       rows_word = '0;
            1:       rows_word = '1;
            default: rows_word = 16'($urandom_range(1, 4));
        endcase
        eff_len  = (len_word[ROWB_W-1:0] == 0) ? 1 : len_word[ROWB_W-1:0];
        eff_rows = (rows_word == 0) ? 1 : rows_word;

        steady_feed  = ($urandom_range(0, 3) == 0);
        steady_drain = ($urandom_range(0, 3) == 0);
        write_registers(pix_word, len_word, rows_word);

        // Open with a restart; later images may follow on without one
        images     = $urandom_range(1, 3);
        with_start = 1'b1;
        repeat (images) begin
            send_image(with_start, eff_len, eff_rows, 8, cut);
            with_start = cut ? 1'b1 : 1'($urandom_range(0, 1));
        end
        wait_idle();
    endtask

    // Reset, directed bytes, random phases, long row, verdict
    initial begin : stimulus
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_data      <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        bytes_sent   = 0;
        steady_feed  = 1'b0;
        steady_drain = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers, extreme data values
        send_byte(8'(FLT_NONE), 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);

        // Shrink the row while one is half done; the next byte ends it
        wait_idle();
        write_registers(16'hFFF1, 16'h8002, 16'h0002);
        send_byte(8'h7F, 1'b0);
        send_byte(8'(FLT_UP), 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);

        // Past the last row the next byte opens row zero, where Up passes raw bytes
        send_byte(8'(FLT_UP), 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'(FLT_SUB), 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'hF5, 1'b0);

        // Unknown filter type zeroes the row, which Average then sees above
        send_byte(UNKNOWN_CODE, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'(FLT_AVG), 1'b0);
        send_byte(8'h01, 1'b0);

        // Restart in the middle of a row, then two Paeth rows
        send_byte(8'(FLT_PAETH), 1'b1);
        send_byte(8'h05, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'(FLT_PAETH), 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        wait_idle();

        while (bytes_sent < TARGET_ITEMS) begin
            random_phase();
        end

        // Long row: out-of-range data saturates the row length
        steady_feed  = 1'b0;
        steady_drain = 1'b0;
        write_registers(16'h0008, 16'hFFFF, 16'h0002);
        send_byte(8'(FLT_PAETH), 1'b1);
        repeat (LONG_ROW_BYTES) send_byte(8'($urandom), 1'b0);
        wait_idle();

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Take results with random stalls, and twice hold off long enough to fill the block
    initial begin : drain
        int gap;
        out_ready     <= 1'b0;
        results_taken = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (results_taken == 400 || results_taken == 900) begin
                gap = HOLD_CYCLES;
            end else begin
                gap = steady_drain ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            results_taken++;
        end
    end

    // Stop a hung run
    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/psu_pkg.sv
rtl/psu_ram.sv
rtl/psu_fifo.sv
rtl/psu_front.sv
rtl/psu_back.sv
rtl/png_scanline_unfilter_top.sv
bench/png_scanline_unfilter_checker.sv
bench/tb_png_scanline_unfilter_top.sv
